### rtl/core/sfa_pkg.sv
package sfa_pkg;

    localparam int INNER_MAX = 1024;
    localparam int AXIS_MAX  = 4096;
    localparam int COL_W     = $clog2(INNER_MAX);
    localparam int POS_W     = $clog2(AXIS_MAX);
    localparam int INNER_W   = COL_W + 1;
    localparam int AXIS_W    = POS_W + 1;
    localparam int ELEM_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_AS_FLOAT = 2'd2;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } best_t;

    // NaN test on raw single-precision bits
    function automatic logic is_nan(input logic [31:0] x);
        is_nan = (x[30:0] > 31'h7f800000);
    endfunction

    // Strict IEEE a > b; NaN never greater, +0 equals -0
    function automatic logic float_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | 32'h80000000);
        kb = b[31] ? ~b : (b | 32'h80000000);
        if (is_nan(a) || is_nan(b))
            float_gt = 1'b0;
        else if ((a[30:0] | b[30:0]) == 31'd0)
            float_gt = 1'b0;
        else
            float_gt = (ka > kb);
    endfunction

    // Exact float32 bits of an axis index
    function automatic logic [31:0] index_to_float(input logic [POS_W-1:0] n);
        logic [4:0]  p;
        logic [34:0] t;
        p = 5'd0;
        for (int i = 0; i < POS_W; i++)
        begin
            if (n[i])
                p = 5'(i);
        end
        t = 35'(n) << (5'd23 - p);
        if (n == '0)
            index_to_float = 32'd0;
        else
            index_to_float = {1'b0, 8'(8'd127 + 8'(p)), t[22:0]};
    endfunction

endpackage

### rtl/core/sfa_best_ram.sv
module sfa_best_ram (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [sfa_pkg::COL_W-1:0] rd_addr,
    output sfa_pkg::best_t            rd_data,
    input  logic                      wr_en,
    input  logic [sfa_pkg::COL_W-1:0] wr_addr,
    input  sfa_pkg::best_t            wr_data
);
    import sfa_pkg::*;

    best_t mem [INNER_MAX];
    best_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/strided_float_argmax.sv
// Streaming argmax along one axis of a float32 tensor fed one element per
// transaction in row-major order (outer group, axis position, inner column).
// One element is accepted every cycle unless out_ready holds back a result;
// group_last marks the last column of a group. Each element reads its column
// entry from a 1024-entry best-value RAM on acceptance and writes it back as
// it leaves the input stage; a forwarding register covers back-to-back hits on
// the same column. Lengths of 0 act as 1 and lengths above 4096/1024 saturate.
// Write configuration only while idle.
module strided_float_argmax (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfa_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   element_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   argmax_word,
    output logic                          group_last
);
    import sfa_pkg::*;

    logic [AXIS_W-1:0]  axis_len_reg;
    logic [INNER_W-1:0] inner_len_reg;
    logic               emit_float_reg;

    logic [COL_W-1:0]   col_cnt_reg;
    logic [POS_W-1:0]   axis_cnt_reg;

    logic               s1_valid_reg;
    logic [ELEM_W-1:0]  s1_elem_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s1_emit_reg;
    logic               s1_last_col_reg;

    logic               fwd_valid_reg;
    logic [COL_W-1:0]   fwd_col_reg;
    best_t              fwd_data_reg;

    logic               out_valid_reg;
    logic [31:0]        out_word_reg;
    logic               out_last_reg;

    logic [AXIS_W-1:0]  axis_eff;
    logic [INNER_W-1:0] inner_eff;
    logic               last_col;
    logic               last_axis;
    logic               in_fire;
    logic               s1_fire;
    best_t              rd_data;
    best_t              old_best;
    best_t              new_best;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_len_reg   <= AXIS_W'(1);
            inner_len_reg  <= INNER_W'(1);
            emit_float_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AXIS_LENGTH:   axis_len_reg   <= cfg_data[AXIS_W-1:0];
                REG_INNER_LENGTH:  inner_len_reg  <= cfg_data[INNER_W-1:0];
                REG_EMIT_AS_FLOAT: emit_float_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective lengths
    always_comb
    begin
        if (axis_len_reg == '0)
            axis_eff = AXIS_W'(1);
        else if (axis_len_reg > AXIS_W'(AXIS_MAX))
            axis_eff = AXIS_W'(AXIS_MAX);
        else
            axis_eff = axis_len_reg;
        if (inner_len_reg == '0)
            inner_eff = INNER_W'(1);
        else if (inner_len_reg > INNER_W'(INNER_MAX))
            inner_eff = INNER_W'(INNER_MAX);
        else
            inner_eff = inner_len_reg;
    end

    assign last_col  = (INNER_W'(col_cnt_reg) + INNER_W'(1)) >= inner_eff;
    assign last_axis = (AXIS_W'(axis_cnt_reg) + AXIS_W'(1)) >= axis_eff;

    // handshake
    assign s1_fire  = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // advance column and axis counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            axis_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_cnt_reg  <= '0;
                axis_cnt_reg <= last_axis ? '0 : axis_cnt_reg + POS_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + COL_W'(1);
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_elem_reg     <= element_bits;
            s1_col_reg      <= col_cnt_reg;
            s1_pos_reg      <= axis_cnt_reg;
            s1_emit_reg     <= last_axis;
            s1_last_col_reg <= last_col;
        end
    end

    sfa_best_ram u_best_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (new_best)
    );

    // compare against the latest best of this column
    always_comb
    begin
        if (fwd_valid_reg && (fwd_col_reg == s1_col_reg))
            old_best = fwd_data_reg;
        else
            old_best = rd_data;
        if ((s1_pos_reg == '0) || float_gt(s1_elem_reg, old_best.value))
        begin
            new_best.value = s1_elem_reg;
            new_best.pos   = s1_pos_reg;
        end
        else
        begin
            new_best = old_best;
        end
    end

    // hold the last write for same-column bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (s1_fire)
            fwd_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            fwd_col_reg  <= s1_col_reg;
            fwd_data_reg <= new_best;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            out_word_reg <= emit_float_reg ? index_to_float(new_best.pos)
                                           : 32'(new_best.pos);
            out_last_reg <= s1_last_col_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign argmax_word = out_word_reg;
    assign group_last  = out_last_reg;

    // a stalled item keeps its column
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stalled item lost its column");

    // a finished last-axis item lands in the result register
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_emit_reg) |=> out_valid_reg)
        else $error("result dropped");

    // backpressure only comes from an occupied input stage
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_emit_reg && out_valid_reg))
        else $error("input stalled without cause");

endmodule
